// ===== rtl/core/cea_pkg.sv =====
// ----------------------------------------------------------------------------
// Charge and energy accumulator package
// Shared types, command and status structures, and fixed constants of the
// charge and energy accumulator core.
// ----------------------------------------------------------------------------
`default_nettype none

package cea_pkg;

   localparam int NOW_W       = 32;
   localparam int MV_W        = 16;
   localparam int CUR_W       = 26;
   localparam int GAP_W       = 16;
   localparam int PERIOD_W    = 31;
   localparam int OUT_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 17;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int WIDE_W      = 64;

   localparam int DIV_RADIX   = 4;
   localparam int REM_W       = 12;

   localparam logic [GAP_W-1:0]    MAX_GAP_RESET = 16'd500;
   localparam logic [GAP_W-1:0]    SUB_GAP_RESET = 16'd250;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 31'd60000;

   localparam logic [REM_W-1:0] DIVISOR_POWER = 12'd1000;
   localparam logic [REM_W-1:0] DIVISOR_SCALE = 12'd3600;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_GAP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUB_GAP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD  = 2'd2;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_RESET  = 2'd1,
      FUNC_POLL   = 2'd2
   } cea_func_type;

   typedef enum logic [1:0] {
      MUL_POWER  = 2'd0,
      MUL_CHARGE = 2'd1,
      MUL_ENERGY = 2'd2
   } cea_mul_sel_type;

   typedef enum logic [1:0] {
      DIV_POWER  = 2'd0,
      DIV_CHARGE = 2'd1,
      DIV_ENERGY = 2'd2
   } cea_div_src_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_MUL_P,
      S_LOAD_P,
      S_RUN_P,
      S_STORE_P,
      S_MUL_C,
      S_ADD_C,
      S_MUL_E,
      S_ADD_E,
      S_LOAD_C,
      S_RUN_C,
      S_STORE_C,
      S_LOAD_E,
      S_RUN_E,
      S_STORE_E,
      S_FINISH
   } cea_state_type;

   typedef struct packed {
      logic            latch;
      logic            apply;
      logic            mul_en;
      cea_mul_sel_type mul_sel;
      logic            add_charge;
      logic            add_energy;
      logic            div_load;
      logic            div_step;
      logic            div_store;
      cea_div_src_type div_src;
      logic            load_out;
   } cea_cmd_type;

   typedef struct packed {
      logic integrate;
      logic div_last;
   } cea_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/cea_datapath.sv =====
// ----------------------------------------------------------------------------
// Charge and energy accumulator datapath
// Holds the configuration and accumulator state, the shared multiplier, the
// shared radix-16 constant divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cea_datapath #(
   parameter int ACCUM_WIDTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire cea_pkg::cea_cmd_type                 cmd,
   output      cea_pkg::cea_status_type              status,
   input  wire logic [1:0]                           req_func,
   input  wire logic [cea_pkg::NOW_W-1:0]            req_now_ms,
   input  wire logic [cea_pkg::MV_W-1:0]             req_bus_mv,
   input  wire logic signed [cea_pkg::CUR_W-1:0]     req_current_ua,
   output      logic signed [cea_pkg::OUT_W-1:0]     rsp_charge_milli_mah,
   output      logic signed [cea_pkg::OUT_W-1:0]     rsp_energy_milli_mwh,
   output      logic [cea_pkg::OUT_W-1:0]            rsp_integrated_ms,
   output      logic                                 rsp_checkpoint_due,
   input  wire logic                                 csr_write,
   input  wire logic [cea_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [cea_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int DIV_W     = cea_pkg::DIV_RADIX * ((ACCUM_WIDTH + cea_pkg::DIV_RADIX - 1)
                                                    / cea_pkg::DIV_RADIX);
   localparam int DIV_STEPS = DIV_W / cea_pkg::DIV_RADIX;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   logic [cea_pkg::GAP_W-1:0]    max_gap_ff, max_gap_in;
   logic [cea_pkg::GAP_W-1:0]    sub_gap_ff, sub_gap_in;
   logic [cea_pkg::PERIOD_W-1:0] period_ff, period_in;

   logic [1:0]                       func_ff;
   logic [cea_pkg::NOW_W-1:0]        now_ff;
   logic [cea_pkg::MV_W-1:0]         mv_ff;
   logic signed [cea_pkg::CUR_W-1:0] cur_ff;

   logic signed [ACCUM_WIDTH-1:0] charge_ff, charge_in;
   logic signed [ACCUM_WIDTH-1:0] energy_ff, energy_in;
   logic [cea_pkg::NOW_W-1:0]     elapsed_ff, elapsed_in;
   logic [cea_pkg::NOW_W-1:0]     prev_ff, prev_in;
   logic                          seen_ff, seen_in;
   logic [cea_pkg::NOW_W-1:0]     deadline_ff, deadline_in;
   logic                          due_ff, due_in;
   logic [cea_pkg::GAP_W-1:0]     dt_ff, dt_in;

   logic [cea_pkg::NOW_W-1:0] dt_raw;
   logic [cea_pkg::GAP_W-1:0] dt_sel;
   logic [cea_pkg::NOW_W-1:0] poll_diff;
   logic [cea_pkg::NOW_W-1:0] rearm_tick;

   logic signed [cea_pkg::MUL_A_W-1:0] mul_a;
   logic signed [cea_pkg::MUL_B_W-1:0] mul_b;
   logic signed [cea_pkg::PROD_W-1:0]  mul_res;
   logic signed [cea_pkg::PROD_W-1:0]  prod_ff;
   logic signed [cea_pkg::WIDE_W-1:0]  prod_ext;

   logic signed [cea_pkg::MUL_A_W-1:0] pw_ff;

   logic signed [cea_pkg::WIDE_W-1:0] div_src_val;
   logic                              div_src_neg;
   logic [cea_pkg::WIDE_W-1:0]        div_src_mag;
   logic [DIV_W-1:0]                  div_quo_ff, div_quo_step;
   logic [cea_pkg::REM_W-1:0]         div_rem_ff, div_rem_step;
   logic [cea_pkg::REM_W-1:0]         div_divisor_ff;
   logic                              div_neg_ff;
   logic [CNT_W-1:0]                  div_cnt_ff;
   logic                              div_high;
   logic [cea_pkg::OUT_W-1:0]         div_sat;
   logic [cea_pkg::MUL_A_W-1:0]       div_mag33;
   logic [cea_pkg::MUL_A_W-1:0]       div_pw;

   logic [cea_pkg::OUT_W-1:0] charge_q_ff;
   logic [cea_pkg::OUT_W-1:0] energy_q_ff;

   always_comb begin
      max_gap_in = max_gap_ff;
      sub_gap_in = sub_gap_ff;
      period_in  = period_ff;
      if (csr_write) begin
         unique case (csr_index)
            cea_pkg::CSR_MAX_GAP: max_gap_in = csr_wdata[cea_pkg::GAP_W-1:0];
            cea_pkg::CSR_SUB_GAP: sub_gap_in = csr_wdata[cea_pkg::GAP_W-1:0];
            cea_pkg::CSR_PERIOD:  period_in  = csr_wdata[cea_pkg::PERIOD_W-1:0];
            default:              max_gap_in = max_gap_ff;
         endcase
      end
   end

   assign dt_raw     = now_ff - prev_ff;
   assign dt_sel     = (dt_raw > {16'd0, max_gap_ff}) ? sub_gap_ff : dt_raw[cea_pkg::GAP_W-1:0];
   assign poll_diff  = now_ff - deadline_ff;
   assign rearm_tick = now_ff + {1'b0, period_ff};

   assign prod_ext = cea_pkg::WIDE_W'(prod_ff);

   always_comb begin
      charge_in   = charge_ff;
      energy_in   = energy_ff;
      elapsed_in  = elapsed_ff;
      prev_in     = prev_ff;
      seen_in     = seen_ff;
      deadline_in = deadline_ff;
      due_in      = due_ff;
      dt_in       = dt_ff;
      if (cmd.apply) begin
         due_in = 1'b0;
         unique case (func_ff)
            cea_pkg::FUNC_SAMPLE: begin
               if (seen_ff) begin
                  dt_in      = dt_sel;
                  elapsed_in = elapsed_ff + {16'd0, dt_sel};
               end
               prev_in = now_ff;
               seen_in = 1'b1;
            end
            cea_pkg::FUNC_RESET: begin
               charge_in   = '0;
               energy_in   = '0;
               elapsed_in  = '0;
               prev_in     = '0;
               seen_in     = 1'b0;
               deadline_in = rearm_tick;
            end
            cea_pkg::FUNC_POLL: begin
               if (!poll_diff[cea_pkg::NOW_W-1]) begin
                  due_in      = 1'b1;
                  deadline_in = rearm_tick;
               end
            end
            default: begin
               due_in = 1'b0;
            end
         endcase
      end
      if (cmd.add_charge) begin
         charge_in = charge_ff + prod_ext[ACCUM_WIDTH-1:0];
      end
      if (cmd.add_energy) begin
         energy_in = energy_ff + prod_ext[ACCUM_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (cmd.mul_sel)
         cea_pkg::MUL_POWER: begin
            mul_a = cea_pkg::MUL_A_W'(cur_ff);
            mul_b = {1'b0, mv_ff};
         end
         cea_pkg::MUL_CHARGE: begin
            mul_a = cea_pkg::MUL_A_W'(cur_ff);
            mul_b = {1'b0, dt_ff};
         end
         cea_pkg::MUL_ENERGY: begin
            mul_a = pw_ff;
            mul_b = {1'b0, dt_ff};
         end
         default: begin
            mul_a = pw_ff;
            mul_b = {1'b0, dt_ff};
         end
      endcase
   end

   assign mul_res = cea_pkg::PROD_W'(mul_a) * cea_pkg::PROD_W'(mul_b);

   always_comb begin
      unique case (cmd.div_src)
         cea_pkg::DIV_POWER:  div_src_val = prod_ext;
         cea_pkg::DIV_CHARGE: div_src_val = cea_pkg::WIDE_W'(charge_ff);
         cea_pkg::DIV_ENERGY: div_src_val = cea_pkg::WIDE_W'(energy_ff);
         default:             div_src_val = prod_ext;
      endcase
   end

   assign div_src_neg = div_src_val[cea_pkg::WIDE_W-1];
   assign div_src_mag = div_src_neg ? (~div_src_val + 64'd1) : div_src_val;

   always_comb begin : div_step_blk
      logic [cea_pkg::REM_W:0] trial;
      div_rem_step = div_rem_ff;
      div_quo_step = div_quo_ff;
      trial        = '0;
      for (int k = 0; k < cea_pkg::DIV_RADIX; k++) begin
         trial        = {div_rem_step, div_quo_step[DIV_W-1]};
         div_quo_step = {div_quo_step[DIV_W-2:0], (trial >= {1'b0, div_divisor_ff})};
         if (trial >= {1'b0, div_divisor_ff}) begin
            div_rem_step = cea_pkg::REM_W'(trial - {1'b0, div_divisor_ff});
         end else begin
            div_rem_step = trial[cea_pkg::REM_W-1:0];
         end
      end
   end

   assign div_high  = |div_quo_ff[DIV_W-1:cea_pkg::OUT_W-1];
   assign div_mag33 = {1'b0, div_quo_ff[cea_pkg::OUT_W-1:0]};
   assign div_pw    = div_neg_ff ? (~div_mag33 + 33'd1) : div_mag33;

   always_comb begin
      if (div_neg_ff) begin
         div_sat = div_high ? 32'h8000_0000 : (~div_quo_ff[cea_pkg::OUT_W-1:0] + 32'd1);
      end else begin
         div_sat = div_high ? 32'h7FFF_FFFF : div_quo_ff[cea_pkg::OUT_W-1:0];
      end
   end

   assign status.integrate = (func_ff == cea_pkg::FUNC_SAMPLE) && seen_ff;
   assign status.div_last  = (div_cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff  <= cea_pkg::MAX_GAP_RESET;
         sub_gap_ff  <= cea_pkg::SUB_GAP_RESET;
         period_ff   <= cea_pkg::PERIOD_RESET;
         charge_ff   <= '0;
         energy_ff   <= '0;
         elapsed_ff  <= '0;
         prev_ff     <= '0;
         seen_ff     <= 1'b0;
         deadline_ff <= {1'b0, cea_pkg::PERIOD_RESET};
         due_ff      <= 1'b0;
      end else begin
         max_gap_ff  <= max_gap_in;
         sub_gap_ff  <= sub_gap_in;
         period_ff   <= period_in;
         charge_ff   <= charge_in;
         energy_ff   <= energy_in;
         elapsed_ff  <= elapsed_in;
         prev_ff     <= prev_in;
         seen_ff     <= seen_in;
         deadline_ff <= deadline_in;
         due_ff      <= due_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff <= dt_in;
      if (cmd.latch) begin
         func_ff <= req_func;
         now_ff  <= req_now_ms;
         mv_ff   <= req_bus_mv;
         cur_ff  <= req_current_ua;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_res;
      end
      if (cmd.div_load) begin
         div_quo_ff     <= div_src_mag[DIV_W-1:0];
         div_rem_ff     <= '0;
         div_neg_ff     <= div_src_neg;
         div_cnt_ff     <= '0;
         div_divisor_ff <= (cmd.div_src == cea_pkg::DIV_POWER) ? cea_pkg::DIVISOR_POWER
                                                               : cea_pkg::DIVISOR_SCALE;
      end else if (cmd.div_step) begin
         div_quo_ff <= div_quo_step;
         div_rem_ff <= div_rem_step;
         div_cnt_ff <= div_cnt_ff + CNT_W'(1);
      end
      if (cmd.div_store) begin
         unique case (cmd.div_src)
            cea_pkg::DIV_POWER:  pw_ff       <= div_pw;
            cea_pkg::DIV_CHARGE: charge_q_ff <= div_sat;
            cea_pkg::DIV_ENERGY: energy_q_ff <= div_sat;
            default:             pw_ff       <= div_pw;
         endcase
      end
      if (cmd.load_out) begin
         rsp_charge_milli_mah <= charge_q_ff;
         rsp_energy_milli_mwh <= energy_q_ff;
         rsp_integrated_ms    <= elapsed_ff;
         rsp_checkpoint_due   <= due_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cea_controller.sv =====
// ----------------------------------------------------------------------------
// Charge and energy accumulator controller
// Sequences each request through decode, multiply (for samples that integrate),
// divide and result load, and owns the request and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cea_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      cea_pkg::cea_cmd_type    cmd,
   input  wire cea_pkg::cea_status_type status
);

   cea_pkg::cea_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != cea_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cea_pkg::S_IDLE:    if (req_valid) state_in = cea_pkg::S_DECODE;
         cea_pkg::S_DECODE:  state_in = status.integrate ? cea_pkg::S_MUL_P : cea_pkg::S_LOAD_C;
         cea_pkg::S_MUL_P:   state_in = cea_pkg::S_LOAD_P;
         cea_pkg::S_LOAD_P:  state_in = cea_pkg::S_RUN_P;
         cea_pkg::S_RUN_P:   if (status.div_last) state_in = cea_pkg::S_STORE_P;
         cea_pkg::S_STORE_P: state_in = cea_pkg::S_MUL_C;
         cea_pkg::S_MUL_C:   state_in = cea_pkg::S_ADD_C;
         cea_pkg::S_ADD_C:   state_in = cea_pkg::S_MUL_E;
         cea_pkg::S_MUL_E:   state_in = cea_pkg::S_ADD_E;
         cea_pkg::S_ADD_E:   state_in = cea_pkg::S_LOAD_C;
         cea_pkg::S_LOAD_C:  state_in = cea_pkg::S_RUN_C;
         cea_pkg::S_RUN_C:   if (status.div_last) state_in = cea_pkg::S_STORE_C;
         cea_pkg::S_STORE_C: state_in = cea_pkg::S_LOAD_E;
         cea_pkg::S_LOAD_E:  state_in = cea_pkg::S_RUN_E;
         cea_pkg::S_RUN_E:   if (status.div_last) state_in = cea_pkg::S_STORE_E;
         cea_pkg::S_STORE_E: state_in = cea_pkg::S_FINISH;
         cea_pkg::S_FINISH:  if (out_free) state_in = cea_pkg::S_IDLE;
         default:            state_in = cea_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = cea_pkg::MUL_POWER;
      cmd.div_src = cea_pkg::DIV_POWER;
      unique case (state_ff)
         cea_pkg::S_IDLE:    cmd.latch = req_valid;
         cea_pkg::S_DECODE:  cmd.apply = 1'b1;
         cea_pkg::S_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cea_pkg::MUL_POWER;
         end
         cea_pkg::S_LOAD_P:  cmd.div_load = 1'b1;
         cea_pkg::S_RUN_P:   cmd.div_step = 1'b1;
         cea_pkg::S_STORE_P: cmd.div_store = 1'b1;
         cea_pkg::S_MUL_C: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cea_pkg::MUL_CHARGE;
         end
         cea_pkg::S_ADD_C:   cmd.add_charge = 1'b1;
         cea_pkg::S_MUL_E: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cea_pkg::MUL_ENERGY;
         end
         cea_pkg::S_ADD_E:   cmd.add_energy = 1'b1;
         cea_pkg::S_LOAD_C: begin
            cmd.div_load = 1'b1;
            cmd.div_src  = cea_pkg::DIV_CHARGE;
         end
         cea_pkg::S_RUN_C: begin
            cmd.div_step = 1'b1;
            cmd.div_src  = cea_pkg::DIV_CHARGE;
         end
         cea_pkg::S_STORE_C: begin
            cmd.div_store = 1'b1;
            cmd.div_src   = cea_pkg::DIV_CHARGE;
         end
         cea_pkg::S_LOAD_E: begin
            cmd.div_load = 1'b1;
            cmd.div_src  = cea_pkg::DIV_ENERGY;
         end
         cea_pkg::S_RUN_E: begin
            cmd.div_step = 1'b1;
            cmd.div_src  = cea_pkg::DIV_ENERGY;
         end
         cea_pkg::S_STORE_E: begin
            cmd.div_store = 1'b1;
            cmd.div_src   = cea_pkg::DIV_ENERGY;
         end
         cea_pkg::S_FINISH:  cmd.load_out = out_free;
         default:            cmd.latch = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cea_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cea_pkg::S_IDLE && req_valid) |=> (state_ff == cea_pkg::S_DECODE))
      else $error("accepted request did not move to decode");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register loaded while a result is still pending");

   a_divide_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cea_pkg::S_RUN_C && !status.div_last) |=> (state_ff == cea_pkg::S_RUN_C))
      else $error("charge division left before its last step");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.apply, cmd.mul_en, cmd.add_charge, cmd.add_energy,
                cmd.div_load, cmd.div_step, cmd.div_store, cmd.load_out}))
      else $error("more than one datapath command in a cycle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/charge_energy_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// Charge and energy accumulator core
// Each request is carried through to its result before the next is accepted:
// a sample that integrates runs three constant divisions in the shared radix-16
// divider, other requests two. A stalled result holds the core in its finish
// state, so no new request is taken until the result register is free.
// Reset is synchronous, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module charge_energy_accumulator_core #(
   parameter int ACCUM_WIDTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [1:0]                           req_func,
   input  wire logic [cea_pkg::NOW_W-1:0]            req_now_ms,
   input  wire logic [cea_pkg::MV_W-1:0]             req_bus_mv,
   input  wire logic signed [cea_pkg::CUR_W-1:0]     req_current_ua,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic signed [cea_pkg::OUT_W-1:0]     rsp_charge_milli_mah,
   output      logic signed [cea_pkg::OUT_W-1:0]     rsp_energy_milli_mwh,
   output      logic [cea_pkg::OUT_W-1:0]            rsp_integrated_ms,
   output      logic                                 rsp_checkpoint_due,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [cea_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [cea_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   cea_pkg::cea_cmd_type    cmd;
   cea_pkg::cea_status_type status;

   assign csr_ready = 1'b1;

   cea_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   cea_datapath #(
      .ACCUM_WIDTH (ACCUM_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_func             (req_func),
      .req_now_ms           (req_now_ms),
      .req_bus_mv           (req_bus_mv),
      .req_current_ua       (req_current_ua),
      .rsp_charge_milli_mah (rsp_charge_milli_mah),
      .rsp_energy_milli_mwh (rsp_energy_milli_mwh),
      .rsp_integrated_ms    (rsp_integrated_ms),
      .rsp_checkpoint_due   (rsp_checkpoint_due),
      .csr_write            (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

endmodule

`default_nettype wire

// ===== tb/charge_energy_accumulator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charge and energy accumulator core test
// Sends sample, reset and poll requests to the core. A predictor keeps its own
// totals, tick and deadline state and expects one result for each request.
// Every result is checked field by field, in order. Directed requests cover
// the first sample, interval limits, timestamp wrap, the checkpoint deadline
// and saturation. Random traffic then runs under several register settings
// and idle patterns, including a long hold-off on the result side.
// ----------------------------------------------------------------------------

module charge_energy_accumulator_core_test;

   localparam logic [1:0]          FUNC_UNUSED   = 2'd3;
   localparam logic signed [25:0]  CUR_MAX       = 26'sh1FFFFFF;
   localparam logic signed [25:0]  CUR_MIN       = 26'sh2000000;
   localparam logic [15:0]         MV_TOP        = 16'd40960;
   localparam longint              POWER_DIVISOR = 64'sd1000;
   localparam longint              MILLI_DIVISOR = 64'sd3600;
   localparam longint              SAT_HIGH      = 64'sd2147483647;
   localparam longint              SAT_LOW       = -64'sd2147483648;
   localparam int                  HOLD_CYCLES   = 1000;
   localparam int                  CYCLE_LIMIT   = 1000000;

   typedef struct {
      logic signed [31:0] charge_milli_mah;
      logic signed [31:0] energy_milli_mwh;
      logic [31:0]        integrated_ms;
      logic               checkpoint_due;
   } reading_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func = cea_pkg::FUNC_SAMPLE;
   logic [31:0]         req_now_ms = '0;
   logic [15:0]         req_bus_mv = '0;
   logic signed [25:0]  req_current_ua = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [31:0]  rsp_charge_milli_mah;
   logic signed [31:0]  rsp_energy_milli_mwh;
   logic [31:0]         rsp_integrated_ms;
   logic                rsp_checkpoint_due;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = cea_pkg::CSR_MAX_GAP;
   logic [31:0]         csr_wdata = '0;

   logic [15:0] gap_limit = cea_pkg::MAX_GAP_RESET;
   logic [15:0] gap_substitute = cea_pkg::SUB_GAP_RESET;
   logic [30:0] checkpoint_period = cea_pkg::PERIOD_RESET;
   longint      charge_total = 0;
   longint      energy_total = 0;
   logic [31:0] integrated_total = '0;
   logic [31:0] seed_tick = '0;
   logic        sample_seen = 1'b0;
   logic [31:0] deadline_tick = 32'(cea_pkg::PERIOD_RESET);

   reading_type expected_readings [$];
   logic [31:0] stim_tick = '0;
   int          send_gap_pct = 0;
   int          stall_pct = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          error_count = 0;
   int          results_checked = 0;
   int          checkpoints_seen = 0;
   int          settings_written = 0;
   int          kind_count [4] = '{0, 0, 0, 0};
   int          cycle_count = 0;

   charge_energy_accumulator_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_now_ms           (req_now_ms),
      .req_bus_mv           (req_bus_mv),
      .req_current_ua       (req_current_ua),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_charge_milli_mah (rsp_charge_milli_mah),
      .rsp_energy_milli_mwh (rsp_energy_milli_mwh),
      .rsp_integrated_ms    (rsp_integrated_ms),
      .rsp_checkpoint_due   (rsp_checkpoint_due),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit of %0d reached", $time, CYCLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic signed [31:0] scale_to_milli(input longint total);
      longint quotient;
      quotient = total / MILLI_DIVISOR;
      if (quotient > SAT_HIGH) return 32'sh7FFFFFFF;
      if (quotient < SAT_LOW) return 32'sh80000000;
      return 32'(quotient);
   endfunction

   task automatic predict_reading(input logic [1:0] func, input logic [31:0] now,
                                  input logic [15:0] mv, input logic signed [25:0] cur);
      reading_type reading;
      logic [31:0] dt;
      logic [31:0] lag;
      longint      power;
      reading.checkpoint_due = 1'b0;
      case (func)
         cea_pkg::FUNC_SAMPLE: begin
            if (sample_seen) begin
               dt = now - seed_tick;
               if (dt > 32'(gap_limit)) dt = 32'(gap_substitute);
               power = (longint'(mv) * longint'(cur)) / POWER_DIVISOR;
               charge_total = charge_total + longint'(cur) * longint'(dt);
               energy_total = energy_total + power * longint'(dt);
               integrated_total = integrated_total + dt;
            end
            seed_tick = now;
            sample_seen = 1'b1;
         end
         cea_pkg::FUNC_RESET: begin
            charge_total = 0;
            energy_total = 0;
            integrated_total = '0;
            seed_tick = '0;
            sample_seen = 1'b0;
            deadline_tick = now + 32'(checkpoint_period);
         end
         cea_pkg::FUNC_POLL: begin
            lag = now - deadline_tick;
            if (!lag[31]) begin
               reading.checkpoint_due = 1'b1;
               deadline_tick = now + 32'(checkpoint_period);
            end
         end
         default: begin
         end
      endcase
      reading.charge_milli_mah = scale_to_milli(charge_total);
      reading.energy_milli_mwh = scale_to_milli(energy_total);
      reading.integrated_ms = integrated_total;
      expected_readings.push_back(reading);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_checker
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %0d %0d %0d %0b",
                     $time, rsp_charge_milli_mah, rsp_energy_milli_mwh,
                     rsp_integrated_ms, rsp_checkpoint_due);
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            check_field("charge_milli_mah", want.charge_milli_mah, rsp_charge_milli_mah);
            check_field("energy_milli_mwh", want.energy_milli_mwh, rsp_energy_milli_mwh);
            check_field("integrated_ms", longint'(want.integrated_ms),
                        longint'(rsp_integrated_ms));
            check_field("checkpoint_due", longint'(want.checkpoint_due),
                        longint'(rsp_checkpoint_due));
            results_checked++;
            if (rsp_checkpoint_due) checkpoints_seen++;
         end
      end
   end

   task automatic send_request(input logic [1:0] func, input logic [31:0] now,
                               input logic [15:0] mv, input logic signed [25:0] cur);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_now_ms <= now;
      req_bus_mv <= mv;
      req_current_ua <= cur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_reading(func, now, mv, cur);
      kind_count[func]++;
      @(negedge clock);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [15:0] gap, input logic [15:0] subst,
                                 input logic [30:0] period);
      logic [1:0]  which [3];
      logic [31:0] value [3];
      which = '{cea_pkg::CSR_MAX_GAP, cea_pkg::CSR_SUB_GAP, cea_pkg::CSR_PERIOD};
      value = '{32'(gap), 32'(subst), 32'(period)};
      drain_results();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= which[i];
         csr_wdata <= value[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      gap_limit = gap;
      gap_substitute = subst;
      checkpoint_period = period;
      settings_written++;
   endtask

   task automatic test_basic_flow;
      // The first sample only seeds the tick; the unused code changes nothing.
      send_request(cea_pkg::FUNC_SAMPLE, 32'd1000, 16'd5000, 26'sd1000);
      send_request(cea_pkg::FUNC_SAMPLE, 32'd1100, MV_TOP, CUR_MAX);
      send_request(cea_pkg::FUNC_SAMPLE, 32'd1350, 16'd0, CUR_MIN);
      send_request(FUNC_UNUSED, 32'd1400, 16'd12345, 26'sd777);
      send_request(cea_pkg::FUNC_SAMPLE, 32'd1400, 16'd3300, -26'sd1);
   endtask

   task automatic test_checkpoint_polls;
      send_request(cea_pkg::FUNC_POLL, 32'd59999, 16'd0, 26'sd0);
      send_request(cea_pkg::FUNC_POLL, 32'd60000, 16'd0, 26'sd0);
      send_request(cea_pkg::FUNC_POLL, 32'd60000, 16'd0, 26'sd0);
      send_request(cea_pkg::FUNC_RESET, 32'hFFFFFF00, 16'd0, 26'sd0);
      send_request(cea_pkg::FUNC_POLL, deadline_tick - 32'd1, 16'd0, 26'sd0);
      send_request(cea_pkg::FUNC_POLL, deadline_tick, 16'd0, 26'sd0);
   endtask

   task automatic test_interval_limits;
      send_request(cea_pkg::FUNC_SAMPLE, 32'hFFFFFFF0, 16'd1000, 26'sd2000);
      send_request(cea_pkg::FUNC_SAMPLE, 32'h00000010, 16'd1000, 26'sd2000);
      send_request(cea_pkg::FUNC_SAMPLE, 32'h00000010 + 32'd500, 16'd2000, -26'sd3000);
      send_request(cea_pkg::FUNC_SAMPLE, 32'h00000010 + 32'd1001, 16'd2000, 26'sd4000);
      send_request(cea_pkg::FUNC_SAMPLE, 32'h00000010 + 32'd996, 16'd2000, 26'sd4000);
      write_settings(16'd0, 16'd0, 31'd1);
      send_request(cea_pkg::FUNC_SAMPLE, 32'h00000010 + 32'd996, 16'd2500, 26'sd5000);
      send_request(cea_pkg::FUNC_SAMPLE, 32'h00000010 + 32'd997, 16'd2500, 26'sd5000);
      write_settings(16'd100, 16'hFFFF, 31'd0);
      send_request(cea_pkg::FUNC_POLL, 32'd77, 16'd0, 26'sd0);
      send_request(cea_pkg::FUNC_POLL, 32'd77, 16'd0, 26'sd0);
   endtask

   task automatic test_saturation;
      write_settings(16'hFFFF, 16'hFFFF, 31'h7FFFFFFF);
      send_request(cea_pkg::FUNC_RESET, 32'd0, 16'd0, 26'sd0);
      send_request(cea_pkg::FUNC_SAMPLE, 32'd100, MV_TOP, CUR_MAX);
      for (int n = 1; n <= 4; n++) begin
         send_request(cea_pkg::FUNC_SAMPLE, 32'd100 + 32'(n) * 32'd65535, MV_TOP, CUR_MAX);
      end
      send_request(cea_pkg::FUNC_RESET, 32'd0, 16'd0, 26'sd0);
      send_request(cea_pkg::FUNC_SAMPLE, 32'd100, MV_TOP, CUR_MIN);
      for (int n = 1; n <= 4; n++) begin
         send_request(cea_pkg::FUNC_SAMPLE, 32'd100 + 32'(n) * 32'd65535, MV_TOP, CUR_MIN);
      end
      send_request(cea_pkg::FUNC_RESET, 32'd500000, 16'd0, 26'sd0);
      stim_tick = 32'd500000;
   endtask

   task automatic test_backpressure;
      int saved_gap;
      saved_gap = send_gap_pct;
      send_gap_pct = 0;
      @(posedge clock);
      hold_requests++;
      @(negedge clock);
      for (int n = 0; n < 6; n++) begin
         stim_tick = stim_tick + 32'd10;
         send_request(cea_pkg::FUNC_SAMPLE, stim_tick, 16'(1200 + n),
                      26'(n * 7000 - 20000));
      end
      send_gap_pct = saved_gap;
   endtask

   task automatic test_random_traffic(input int count);
      int                 pick;
      int                 step;
      int                 shape;
      logic [1:0]         func;
      logic [15:0]        mv;
      logic signed [25:0] cur;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         step = $urandom_range(99);
         if (step < 70) stim_tick = stim_tick + $urandom_range(0, 32'(gap_limit) + 2);
         else if (step < 78) stim_tick = stim_tick + 32'(gap_limit) + $urandom_range(0, 1);
         else if (step < 86) stim_tick = stim_tick + $urandom;
         else if (step < 92) stim_tick = stim_tick - $urandom_range(1, 50);
         else stim_tick = deadline_tick + $urandom_range(0, 4) - 32'd2;
         if (pick < 3) func = cea_pkg::FUNC_RESET;
         else if (pick < 5) func = FUNC_UNUSED;
         else if (pick < 18) func = cea_pkg::FUNC_POLL;
         else func = cea_pkg::FUNC_SAMPLE;
         shape = $urandom_range(99);
         if (shape < 55) cur = 26'($urandom);
         else if (shape < 80) cur = 26'($urandom_range(0, 4000)) - 26'sd2000;
         else if (shape < 90) cur = $urandom_range(1) ? CUR_MAX : CUR_MIN;
         else cur = 26'sd0;
         if ($urandom_range(9) == 0) mv = $urandom_range(1) ? MV_TOP : 16'd0;
         else mv = 16'($urandom_range(0, 40960));
         send_request(func, stim_tick, mv, cur);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_gap_pct = 26;
      stall_pct = 61;
      test_basic_flow();
      test_checkpoint_polls();
      test_interval_limits();
      test_saturation();
      write_settings(cea_pkg::MAX_GAP_RESET, cea_pkg::SUB_GAP_RESET, cea_pkg::PERIOD_RESET);
      test_random_traffic(85);
      write_settings(16'($urandom), 16'($urandom), 31'($urandom));
      test_random_traffic(85);

      send_gap_pct = 61;
      stall_pct = 26;
      write_settings(16'd0, 16'($urandom), 31'd1);
      test_random_traffic(85);
      test_backpressure();
      write_settings(16'hFFFF, 16'hFFFF, 31'h7FFFFFFF);
      test_random_traffic(85);

      send_gap_pct = 0;
      stall_pct = 0;
      write_settings(16'($urandom_range(1, 2000)), 16'($urandom), 31'd0);
      test_random_traffic(85);
      write_settings(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
                     31'($urandom_range(1, 100000)));
      test_random_traffic(85);

      drain_results();
      repeat (300) @(posedge clock);
      $display("Sent %0d samples, %0d total resets, %0d polls and %0d unused codes",
               kind_count[cea_pkg::FUNC_SAMPLE], kind_count[cea_pkg::FUNC_RESET],
               kind_count[cea_pkg::FUNC_POLL], kind_count[FUNC_UNUSED]);
      $display("under %0d register settings; %0d results checked, %0d checkpoints due.",
               settings_written, results_checked, checkpoints_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
